// ----- hdl/rmf2d_pkg.sv -----
// shared types and constants of the rgb median filter
`timescale 1ns / 1ps
`default_nettype none
package rmf2d_pkg;
  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;
  localparam int unsigned MAX_HALF   = 7;
  localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       req_type;
    logic [6:0] x_pos;
    logic [6:0] y_pos;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       status;
  } res_t;
endpackage
`default_nettype wire

// ----- hdl/rgb_median_filter_2d.sv -----
// top level of the rgb median filter over a stored image
//
// usage
//   a word is offered on req_i with start_i high; it is taken at a clock
//   edge where busy_o is low. a store word writes one pixel and gives
//   no result; a store outside the image is dropped.
//   a read word outside the image answers in the next cycle with status 1.
//   a read word inside the image finds the median per channel by a
//   bit-serial radix select: eight passes over the clipped window, one
//   bit of every channel's answer settled per pass, one pixel store read
//   per cycle; a window holds at most 15 by 15 pixels, and the single
//   read port of the pixel store makes each pass read one pixel at a time.
//   the result word sits on res_o for one cycle with valid_o high; the
//   receiver cannot hold it off.
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle.
//   reset restores 128 x 128 and half window 1; the pixel store is not
//   cleared and reads of never written pixels are undefined.
`timescale 1ns / 1ps
`default_nettype none
module rgb_median_filter_2d (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire rmf2d_pkg::req_t   req_i,
  output logic                   valid_o,
  output rmf2d_pkg::res_t        res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [7:0]        cfg_data_i
);

  // configuration registers
  logic [7:0] width_q, height_q;
  logic [2:0] half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd128;
      height_q <= 8'd128;
      half_q   <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmf2d_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rmf2d_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        rmf2d_pkg::REG_HALF:   half_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated
  logic [7:0] w_eff, h_eff;
  logic [2:0] hw_eff;
  assign w_eff  = (width_q > 8'(rmf2d_pkg::MAX_WIDTH)) ? 8'(rmf2d_pkg::MAX_WIDTH) : width_q;
  assign h_eff  = (height_q > 8'(rmf2d_pkg::MAX_HEIGHT)) ? 8'(rmf2d_pkg::MAX_HEIGHT)
                                                          : height_q;
  assign hw_eff = (half_q == 3'd0) ? 3'd1 : half_q;

  logic accept, in_img;
  assign accept = start_i && !busy_o;
  assign in_img = ({1'b0, req_i.x_pos} < w_eff) && ({1'b0, req_i.y_pos} < h_eff);

  // clipped window bounds
  logic [7:0] xs, ys, wm1, hm1;
  logic [6:0] x0, x1, y0, y1;
  logic [3:0] dx, dy;
  logic [7:0] n_win;
  assign xs  = {1'b0, req_i.x_pos} + {5'd0, hw_eff};
  assign ys  = {1'b0, req_i.y_pos} + {5'd0, hw_eff};
  assign wm1 = w_eff - 8'd1;
  assign hm1 = h_eff - 8'd1;
  assign x0  = (req_i.x_pos > {4'd0, hw_eff}) ? req_i.x_pos - {4'd0, hw_eff} : 7'd0;
  assign y0  = (req_i.y_pos > {4'd0, hw_eff}) ? req_i.y_pos - {4'd0, hw_eff} : 7'd0;
  assign x1  = (xs < wm1) ? xs[6:0] : wm1[6:0];
  assign y1  = (ys < hm1) ? ys[6:0] : hm1[6:0];
  assign dx  = 4'(x1 - x0);
  assign dy  = 4'(y1 - y0);
  assign n_win = ({4'd0, dx} + 8'd1) * ({4'd0, dy} + 8'd1);

  // control
  rmf2d_pkg::state_e state_q, state_d;
  logic [6:0] ci_q, cj_q, x0_q, x1_q, y0_q, y1_q;
  logic [7:0] n_q, bit_q, mask_q;
  logic       vld_q;
  logic       last_addr;
  assign last_addr = (ci_q == x1_q) && (cj_q == y1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmf2d_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  logic       res_valid_d;
  rmf2d_pkg::res_t res_d;
  logic [7:0] pfx_q [2][3];
  logic [8:0] avg [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      avg[c] = ({1'b0, pfx_q[0][c]} + {1'b0, pfx_q[1][c]}) >> 1;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      rmf2d_pkg::ST_IDLE: begin
        if (accept && req_i.req_type == rmf2d_pkg::REQ_READ) begin
          if (in_img) begin
            state_d = rmf2d_pkg::ST_WALK;
          end else begin
            res_valid_d  = 1'b1;
            res_d.status = 1'b1;
          end
        end
      end
      rmf2d_pkg::ST_WALK:  if (last_addr) state_d = rmf2d_pkg::ST_DRAIN;
      rmf2d_pkg::ST_DRAIN: state_d = rmf2d_pkg::ST_STEP;
      rmf2d_pkg::ST_STEP:  state_d = bit_q[0] ? rmf2d_pkg::ST_DONE : rmf2d_pkg::ST_WALK;
      rmf2d_pkg::ST_DONE: begin
        state_d         = rmf2d_pkg::ST_IDLE;
        res_valid_d     = 1'b1;
        res_d.red_out   = avg[0][7:0];
        res_d.green_out = avg[1][7:0];
        res_d.blue_out  = avg[2][7:0];
      end
      default: state_d = rmf2d_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != rmf2d_pkg::ST_IDLE);

  // pixel store, {red, green, blue} at {x, y}
  logic [23:0] mem [rmf2d_pkg::DEPTH];
  logic [23:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && req_i.req_type == rmf2d_pkg::REQ_STORE && in_img) begin
      mem[{req_i.x_pos, req_i.y_pos}] <= {req_i.red_in, req_i.green_in, req_i.blue_in};
    end
    rd_q <= mem[{ci_q, cj_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= (state_q == rmf2d_pkg::ST_WALK);
      valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  // radix select: per channel two trackers, rank mid and mid-1 (both mid for an odd window)
  logic [7:0] chan [3];
  logic [7:0] k_q   [2][3];
  logic [7:0] cnt_q [2][3];
  logic       hit   [2][3];
  assign chan[0] = rd_q[23:16];
  assign chan[1] = rd_q[15:8];
  assign chan[2] = rd_q[7:0];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int c = 0; c < 3; c++) begin
        hit[s][c] = (((chan[c] ^ pfx_q[s][c]) & mask_q) == 8'd0) &&
                    ((chan[c] & bit_q) == 8'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rmf2d_pkg::ST_IDLE) begin
      x0_q   <= x0;
      x1_q   <= x1;
      y0_q   <= y0;
      y1_q   <= y1;
      ci_q   <= x0;
      cj_q   <= y0;
      n_q    <= n_win;
      bit_q  <= 8'h80;
      mask_q <= 8'h00;
      for (int c = 0; c < 3; c++) begin
        pfx_q[0][c] <= 8'd0;
        pfx_q[1][c] <= 8'd0;
        cnt_q[0][c] <= 8'd0;
        cnt_q[1][c] <= 8'd0;
        k_q[0][c]   <= n_win >> 1;
        k_q[1][c]   <= n_win[0] ? (n_win >> 1) : (n_win >> 1) - 8'd1;
      end
    end else begin
      if (state_q == rmf2d_pkg::ST_WALK) begin
        if (cj_q == y1_q) begin
          cj_q <= y0_q;
          ci_q <= ci_q + 7'd1;
        end else begin
          cj_q <= cj_q + 7'd1;
        end
      end
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < 3; c++) begin
          if (vld_q && hit[s][c]) cnt_q[s][c] <= cnt_q[s][c] + 8'd1;
        end
      end
      if (state_q == rmf2d_pkg::ST_STEP) begin
        ci_q   <= x0_q;
        cj_q   <= y0_q;
        bit_q  <= bit_q >> 1;
        mask_q <= mask_q | bit_q;
        for (int s = 0; s < 2; s++) begin
          for (int c = 0; c < 3; c++) begin
            cnt_q[s][c] <= 8'd0;
            // rank beyond the zeros: this bit is one
            if (k_q[s][c] >= cnt_q[s][c]) begin
              pfx_q[s][c] <= pfx_q[s][c] | bit_q;
              k_q[s][c]   <= k_q[s][c] - cnt_q[s][c];
            end
          end
        end
      end
    end
  end

  // checks
  a_walk_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmf2d_pkg::ST_WALK |->
      ci_q >= x0_q && ci_q <= x1_q && cj_q >= y0_q && cj_q <= y1_q)
    else $error("window walk left the clipped window");

  a_step_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmf2d_pkg::ST_STEP |-> !vld_q)
    else $error("pixel data pending during bit step");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != rmf2d_pkg::ST_IDLE |-> cnt_q[0][0] <= n_q && cnt_q[1][2] <= n_q)
    else $error("count exceeds window size");

  a_read_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.req_type == rmf2d_pkg::REQ_READ && in_img |=> busy_o && !valid_o)
    else $error("in-range read did not start a window walk");

endmodule
`default_nettype wire

// ----- dv/rgb_median_filter_2d_tb.sv -----
// testbench of the rgb median filter: scoreboard with its own image copy, directed and random words
`timescale 1ns / 1ps
`default_nettype none
module rgb_median_filter_2d_tb;

  // scoreboard: holds a copy of the image and the configuration,
  // predicts one result per read word and checks results in order
  class median_scoreboard;
    logic [23:0] image_copy [rmf2d_pkg::DEPTH];
    bit          written [rmf2d_pkg::DEPTH];
    int unsigned width_cfg, height_cfg, half_cfg;
    rmf2d_pkg::res_t pending_q[$];
    int          err_cnt;

    function void reset_cfg();
      width_cfg = 128; height_cfg = 128; half_cfg = 1;
    endfunction

    function void write_cfg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        rmf2d_pkg::REG_WIDTH:  width_cfg = 32'(data);
        rmf2d_pkg::REG_HEIGHT: height_cfg = 32'(data);
        rmf2d_pkg::REG_HALF:   half_cfg = 32'(data[2:0]);
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      return width_cfg > rmf2d_pkg::MAX_WIDTH ? rmf2d_pkg::MAX_WIDTH : width_cfg;
    endfunction

    function int unsigned eff_h();
      return height_cfg > rmf2d_pkg::MAX_HEIGHT ? rmf2d_pkg::MAX_HEIGHT : height_cfg;
    endfunction

    function int unsigned eff_half();
      int unsigned hw;
      hw = half_cfg == 0 ? 1 : half_cfg;
      return hw > rmf2d_pkg::MAX_HALF ? rmf2d_pkg::MAX_HALF : hw;
    endfunction

    // window bounds, clipped at the borders
    function void window_of(int unsigned x, int unsigned y, output int unsigned x0,
                            output int unsigned x1, output int unsigned y0,
                            output int unsigned y1);
      int unsigned hw;
      hw = eff_half();
      x0 = x > hw ? x - hw : 0;
      y0 = y > hw ? y - hw : 0;
      x1 = (x + hw < eff_w() - 1) ? x + hw : eff_w() - 1;
      y1 = (y + hw < eff_h() - 1) ? y + hw : eff_h() - 1;
    endfunction

    // true when every pixel of the clipped window has been written, or the position is outside the image
    function bit window_written(int unsigned x, int unsigned y);
      int unsigned x0, x1, y0, y1;
      if (x >= eff_w() || y >= eff_h()) return 1;
      window_of(x, y, x0, x1, y0, y1);
      for (int unsigned i = x0; i <= x1; i++)
        for (int unsigned j = y0; j <= y1; j++)
          if (!written[i * rmf2d_pkg::MAX_HEIGHT + j]) return 0;
      return 1;
    endfunction

    // median of one channel by sorting
    function logic [7:0] channel_median(int ch, int unsigned x, int unsigned y);
      int unsigned x0, x1, y0, y1, n;
      logic [7:0] vals[$];
      window_of(x, y, x0, x1, y0, y1);
      for (int unsigned i = x0; i <= x1; i++)
        for (int unsigned j = y0; j <= y1; j++)
          vals = {vals, 8'(image_copy[i * rmf2d_pkg::MAX_HEIGHT + j] >> (8 * ch))};
      vals.sort();
      n = vals.size();
      if (n % 2 == 0) return 8'((9'(vals[n/2]) + 9'(vals[n/2 - 1])) >> 1);
      return vals[n/2];
    endfunction

    function void note_word(rmf2d_pkg::req_t w);
      rmf2d_pkg::res_t r;
      bit in_img;
      in_img = w.x_pos < eff_w() && w.y_pos < eff_h();
      if (w.req_type == rmf2d_pkg::REQ_STORE) begin
        if (in_img) begin
          image_copy[w.x_pos * rmf2d_pkg::MAX_HEIGHT + w.y_pos] =
            {w.red_in, w.green_in, w.blue_in};
          written[w.x_pos * rmf2d_pkg::MAX_HEIGHT + w.y_pos] = 1;
        end
        return;
      end
      r = '0;
      if (!in_img) r.status = 1'b1;
      else begin
        r.red_out   = channel_median(2, w.x_pos, w.y_pos);
        r.green_out = channel_median(1, w.x_pos, w.y_pos);
        r.blue_out  = channel_median(0, w.x_pos, w.y_pos);
      end
      pending_q = {pending_q, r};
    endfunction

    task check_result(rmf2d_pkg::res_t got);
      rmf2d_pkg::res_t exp_r;
      if (pending_q.size() == 0) begin
        report_err("result with nothing pending", 0, 0);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.red_out != exp_r.red_out) report_err("red_out", got.red_out, exp_r.red_out);
      if (got.green_out != exp_r.green_out)
        report_err("green_out", got.green_out, exp_r.green_out);
      if (got.blue_out != exp_r.blue_out) report_err("blue_out", got.blue_out, exp_r.blue_out);
      if (got.status != exp_r.status) report_err("status", got.status, exp_r.status);
    endtask

    task report_err(string what, int got, int want);
      err_cnt++;
      if (err_cnt <= 40) $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask
  endclass

  logic clk, rst_n, start, busy, valid, cfg_we;
  rmf2d_pkg::req_t req;
  rmf2d_pkg::res_t res;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;
  median_scoreboard sb;
  int burst_left;

  rgb_median_filter_2d dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .req_i(req),
    .valid_o(valid), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // result monitor; the receiver cannot stall, so every strobe is a word
  always @(posedge clk) begin
    if (rst_n && valid) sb.check_result(res);
  end

  // offer one word and hold it until taken; bursts with random gaps between
  task automatic send_word(rmf2d_pkg::req_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= w;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_word(w);
    @(negedge clk);
  endtask

  // stop offering, wait for all results, then let a store still in flight settle
  task automatic drain();
    start <= 1'b0;
    req   <= 39'({$urandom, $urandom});
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] data);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_cfg(idx, data);
  endtask

  function automatic rmf2d_pkg::req_t make_word(bit rd, int x, int y);
    rmf2d_pkg::req_t w;
    w = 39'({$urandom, $urandom});
    w.req_type = rd ? rmf2d_pkg::REQ_READ : rmf2d_pkg::REQ_STORE;
    w.x_pos = 7'(x); w.y_pos = 7'(y);
    return w;
  endfunction

  // fill the first w x h pixels; extreme colors on some
  task automatic fill_image(int w, int h);
    rmf2d_pkg::req_t wd;
    for (int i = 0; i < w; i++)
      for (int j = 0; j < h; j++) begin
        wd = make_word(0, i, j);
        case ($urandom_range(0, 5))
          0: {wd.red_in, wd.green_in, wd.blue_in} = '0;
          1: {wd.red_in, wd.green_in, wd.blue_in} = '1;
          default: ;
        endcase
        send_word(wd);
      end
  endtask

  // read and store at random, keeping out of never written pixels; some out of range
  task automatic random_reads(int count, int w, int h);
    int x, y;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        x = $urandom_range(0, 127); y = $urandom_range(0, 127);
      end else begin
        x = $urandom_range(0, w - 1); y = $urandom_range(0, h - 1);
      end
      if (!sb.window_written(x, y)) continue;
      if ($urandom_range(0, 3) == 0) send_word(make_word(0, x, y));
      else send_word(make_word(1, x, y));
    end
  endtask

  initial begin
    #20_000_000;
    $display("rgb_median_filter_2d_tb: errors");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_cfg();
    burst_left = 0;
    rst_n = 1'b0; start = 1'b0; req = '0;
    cfg_we = 1'b0; cfg_idx = rmf2d_pkg::REG_WIDTH; cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: tiny 3 x 3 image, corners, center, out of range, extremes
    set_reg(rmf2d_pkg::REG_WIDTH, 8'd3);
    set_reg(rmf2d_pkg::REG_HEIGHT, 8'd3);
    set_reg(rmf2d_pkg::REG_HALF, 8'd0);
    fill_image(3, 3);
    send_word(make_word(1, 0, 0));
    send_word(make_word(1, 1, 1));
    send_word(make_word(1, 2, 2));
    send_word(make_word(1, 3, 0));
    send_word(make_word(1, 127, 127));
    send_word(make_word(0, 0, 127));
    send_word(make_word(1, 0, 2));
    set_reg(rmf2d_pkg::REG_HALF, 8'd7);
    send_word(make_word(1, 1, 0));
    // zero size: all out of range
    set_reg(rmf2d_pkg::REG_WIDTH, 8'd0);
    send_word(make_word(0, 0, 0));
    send_word(make_word(1, 0, 0));
    // size above max saturates; the far columns are written before they are read
    set_reg(rmf2d_pkg::REG_WIDTH, 8'd255);
    set_reg(rmf2d_pkg::REG_HEIGHT, 8'd3);
    set_reg(rmf2d_pkg::REG_HALF, 8'd1);
    for (int i = 126; i < 128; i++)
      for (int j = 0; j < 3; j++) send_word(make_word(0, i, j));
    send_word(make_word(1, 127, 1));
    send_word(make_word(1, 1, 1));

    // pause until every result is in
    drain();

    // random phases over several settings, small images mostly
    for (int ph = 0; ph < 6; ph++) begin
      int w, h;
      w = (ph == 5) ? 128 : $urandom_range(1, 12);
      h = (ph == 4) ? 128 : $urandom_range(1, 12);
      if (ph == 5) h = 2;
      if (ph == 4) w = 1;
      set_reg(rmf2d_pkg::REG_WIDTH, 8'(w));
      set_reg(rmf2d_pkg::REG_HEIGHT, 8'(h));
      set_reg(rmf2d_pkg::REG_HALF, 8'($urandom_range(0, 7)));
      fill_image(w, h);
      random_reads(40, w, h);
    end

    drain();
    repeat (50) @(negedge clk);
    if (sb.err_cnt == 0 && sb.pending_q.size() == 0) begin
      $display("rgb_median_filter_2d_tb: clean");
    end else begin
      $display("rgb_median_filter_2d_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
